>>> rtl/ssfp_pkg.sv
// Shared types and constants for the servo status frame parser.
// Depends on nothing; imported by the top level and the testbench.
package ssfp_pkg;

    localparam int SLOTS     = 4;
    localparam int MAX_FRAME = 32;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = 6;
    localparam int CFG_N     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int BODY_N    = 3;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LEN  = 8'd2;
    localparam logic [7:0] POS_LEN  = 8'd4;
    // frame length is LEN plus two header bytes, ID and LEN bytes; LEN counts body and checksum bytes
    localparam logic [7:0] OVERHEAD = 8'd4;
    // first body byte sits at this frame position
    localparam logic [CNT_W-1:0] BODY_POS = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ID   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_LENB = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_HDR1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(MAX_FRAME);

    typedef enum logic [1:0] {
        ST_KNOWN   = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_CKSUM   = 2'd2
    } t_frame_status;

    typedef struct packed {
        logic [15:0] position;
        logic        pos_known;
        logic [7:0]  status;
        logic [31:0] good_count;
        logic [31:0] ck_count;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

endpackage

>>> rtl/ssfp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds while the read enable is low.
module ssfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/servo_status_frame_parser.sv
// Servo status frame parser: one received byte per cycle unless stalled, one result per frame.
// After its checksum byte is accepted, a result goes through the slot RAM read, then
// the update and output register. Throughput: one byte per cycle;
// input stalls only while a finished result is blocked behind a stalled output.
// Reset (synchronous, active low) clears the parser, slot IDs to 1..4, slot valid
// bits and handshake state; slot RAM entries read as zero until first written.
module servo_status_frame_parser
    import ssfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output logic [1:0]           o_frame_status,
    output logic [7:0]           o_frame_id,
    output logic                 o_slot_hit,
    output logic [1:0]           o_slot_index,
    output logic [7:0]           o_status_byte,
    output logic                 o_position_reply,
    output logic [15:0]          o_position,
    output logic                 o_position_known,
    output logic [31:0]          o_rx_frames,
    output logic [31:0]          o_checksum_errors,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // configuration
    logic [7:0] r_cfg [CFG_N];

    // parser state
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [CNT_W-1:0] r_exp_size, n_exp_size;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_frame_id, n_frame_id;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_body [BODY_N];
    logic             r_seen [SLOTS];

    // frame end stage
    logic              a_end;
    logic              a_good;
    logic              a_hit;
    logic [SLOT_W-1:0] a_slot;

    logic              r_b_valid;
    logic              r_b_good;
    logic              r_b_hit;
    logic [SLOT_W-1:0] r_b_slot;
    logic [7:0]        r_b_id;
    logic [7:0]        r_b_status;
    logic              r_b_pos_reply;
    logic [15:0]       r_b_pos;
    logic              b_go;

    logic [REC_W-1:0]  ram_rdata;
    t_slot_rec         rec_old, rec_new;
    logic              ram_we;
    t_frame_status     b_status;

    // output register
    logic              r_o_valid;
    t_frame_status     r_o_status;
    logic [7:0]        r_o_id;
    logic              r_o_hit;
    logic [SLOT_W-1:0] r_o_slot;
    logic [7:0]        r_o_status_byte;
    logic              r_o_pos_reply;
    t_slot_rec         r_o_rec;

    logic rx_acc;

    assign b_go       = !r_o_valid || !i_res_stall;
    assign o_rx_stall = r_b_valid && !b_go;
    assign rx_acc     = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_byte_count = r_byte_count;
        n_exp_size   = r_exp_size;
        n_sum        = r_sum;
        n_frame_id   = r_frame_id;
        n_len        = r_len;
        a_end        = 1'b0;
        a_good       = (i_rx_byte == ~r_sum);
        if (rx_acc) begin
            priority if (r_byte_count == '0) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_byte_count = CNT_HDR1;
                end
            end else if (r_byte_count == CNT_HDR1) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_byte_count = POS_ID;
                end else begin
                    n_byte_count = '0;
                    n_exp_size   = '0;
                    n_sum        = '0;
                end
            end else if (r_byte_count >= CNT_LIM) begin
                n_byte_count = (i_rx_byte == HDR_BYTE) ? CNT_HDR1 : '0;
                n_exp_size   = '0;
                n_sum        = '0;
            end else begin
                n_byte_count = r_byte_count + CNT_W'(1);
                priority if (r_byte_count == POS_ID) begin
                    n_frame_id = i_rx_byte;
                    n_sum      = r_sum + i_rx_byte;
                end else if (r_byte_count == POS_LENB) begin
                    n_len = i_rx_byte;
                    n_sum = r_sum + i_rx_byte;
                    if (i_rx_byte < MIN_LEN
                        || ({1'b0, i_rx_byte} + {1'b0, OVERHEAD}) > 9'(MAX_FRAME)) begin
                        // drop the frame and resynchronize
                        n_byte_count = '0;
                        n_exp_size   = '0;
                        n_sum        = '0;
                    end else begin
                        n_exp_size = CNT_W'(i_rx_byte + OVERHEAD);
                    end
                end else if (CNT_W'(r_byte_count + CNT_W'(1)) != r_exp_size) begin
                    n_sum = r_sum + i_rx_byte;
                end else begin
                    // checksum byte closes the frame
                    a_end        = 1'b1;
                    n_byte_count = '0;
                    n_exp_size   = '0;
                    n_sum        = '0;
                end
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        a_hit  = 1'b0;
        a_slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (((k < CFG_N) ? r_cfg[k] : 8'(k + 1)) == r_frame_id) begin
                a_hit  = 1'b1;
                a_slot = SLOT_W'(k);
            end
        end
    end

    ssfp_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_slot),
        .i_wdata (rec_new),
        .i_re    (a_end),
        .i_raddr (a_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rec_old = r_seen[r_b_slot] ? t_slot_rec'(ram_rdata) : '0;
        rec_new = rec_old;
        if (r_b_good) begin
            rec_new.status     = r_b_status;
            rec_new.good_count = rec_old.good_count + 32'd1;
            if (r_b_pos_reply && r_b_status == '0) begin
                rec_new.position  = r_b_pos;
                rec_new.pos_known = 1'b1;
            end
        end else begin
            rec_new.ck_count = rec_old.ck_count + 32'd1;
        end
        if (!r_b_good) begin
            b_status = ST_CKSUM;
        end else if (r_b_hit) begin
            b_status = ST_KNOWN;
        end else begin
            b_status = ST_UNKNOWN;
        end
    end

    assign ram_we = r_b_valid && b_go && r_b_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) begin
                r_cfg[i] <= 8'(i + 1);
            end
            for (int i = 0; i < SLOTS; i++) begin
                r_seen[i] <= 1'b0;
            end
            r_byte_count <= '0;
            r_exp_size   <= '0;
            r_sum        <= '0;
            r_frame_id   <= '0;
            r_len        <= '0;
            r_b_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            r_byte_count <= n_byte_count;
            r_exp_size   <= n_exp_size;
            r_sum        <= n_sum;
            r_frame_id   <= n_frame_id;
            r_len        <= n_len;
            if (ram_we) begin
                r_seen[r_b_slot] <= 1'b1;
            end
            // hold the finished frame while the output is blocked
            if (a_end) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (r_b_valid && b_go) begin
                r_o_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rx_acc && r_byte_count >= BODY_POS && r_byte_count < CNT_LIM && !a_end) begin
            for (int j = 0; j < BODY_N; j++) begin
                if (r_byte_count == BODY_POS + CNT_W'(j)) begin
                    r_body[j] <= i_rx_byte;
                end
            end
        end
        if (a_end) begin
            r_b_good      <= a_good;
            r_b_hit       <= a_hit;
            r_b_slot      <= a_slot;
            r_b_id        <= r_frame_id;
            r_b_status    <= r_body[0];
            r_b_pos_reply <= a_good && (r_len == POS_LEN);
            r_b_pos       <= {r_body[1], r_body[2]};
        end
        if (r_b_valid && b_go) begin
            r_o_status      <= b_status;
            r_o_id          <= r_b_id;
            r_o_hit         <= r_b_hit;
            r_o_slot        <= r_b_hit ? r_b_slot : '0;
            r_o_status_byte <= r_b_status;
            r_o_pos_reply   <= r_b_pos_reply;
            r_o_rec         <= r_b_hit ? rec_new : '0;
        end
    end

    assign o_res_valid       = r_o_valid;
    assign o_frame_status    = r_o_status;
    assign o_frame_id        = r_o_id;
    assign o_slot_hit        = r_o_hit;
    assign o_slot_index      = 2'(r_o_slot);
    assign o_status_byte     = r_o_status_byte;
    assign o_position_reply  = r_o_pos_reply;
    assign o_position        = r_o_rec.position;
    assign o_position_known  = r_o_rec.pos_known;
    assign o_rx_frames       = r_o_rec.good_count;
    assign o_checksum_errors = r_o_rec.ck_count;

`ifndef SYNTHESIS
    // a frame is at least six bytes, so two read-modify-writes never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !a_end)
        else $error("frame end while previous slot update pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count < CNT_LIM)
        else $error("byte count ran past the frame limit");

    a_known_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_KNOWN) |-> r_o_hit)
        else $error("known-slot status without a slot hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_hit) |-> (r_o_rec == '0 && r_o_slot == '0))
        else $error("slot fields nonzero on an unmatched frame");

    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> !ram_we)
        else $error("slot record written on consecutive cycles");
`endif

endmodule

>>> tb/servo_status_frame_parser_tb.sv
// Self-checking testbench for servo_status_frame_parser: directed frames, then random byte streams.
// Directed frames are checked against typed expectations, random ones against a frame predictor.
// Depends on ssfp_pkg and the servo_status_frame_parser RTL.
module servo_status_frame_parser_tb
    import ssfp_pkg::*;
();

    localparam int RESULT_LATENCY = 2;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 270;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ID = CFG_IDX_W'(0);

    typedef struct packed {
        t_frame_status status;
        logic [7:0]    id;
        logic          hit;
        logic [1:0]    index;
        logic [7:0]    stat_byte;
        logic          pos_reply;
        logic [15:0]   position;
        logic          pos_known;
        logic [31:0]   rx_frames;
        logic [31:0]   ck_errors;
    } t_frame_result;

    typedef struct {
        logic [7:0] rx;
        int         sel;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_rx_valid = 1'b0;
    logic                 o_rx_stall;
    logic [7:0]           i_rx_byte = 8'h00;
    logic                 o_res_valid;
    logic                 i_res_stall = 1'b0;
    logic [1:0]           o_frame_status;
    logic [7:0]           o_frame_id;
    logic                 o_slot_hit;
    logic [1:0]           o_slot_index;
    logic [7:0]           o_status_byte;
    logic                 o_position_reply;
    logic [15:0]          o_position;
    logic                 o_position_known;
    logic [31:0]          o_rx_frames;
    logic [31:0]          o_checksum_errors;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'h00;

    servo_status_frame_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_frame_status    (o_frame_status),
        .o_frame_id        (o_frame_id),
        .o_slot_hit        (o_slot_hit),
        .o_slot_index      (o_slot_index),
        .o_status_byte     (o_status_byte),
        .o_position_reply  (o_position_reply),
        .o_position        (o_position),
        .o_position_known  (o_position_known),
        .o_rx_frames       (o_rx_frames),
        .o_checksum_errors (o_checksum_errors),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [CNT_W-1:0] pr_count = '0;
    logic [CNT_W-1:0] pr_size = '0;
    logic [7:0]       pr_sum = 8'h00;
    logic [7:0]       pr_id = 8'h00;
    logic [7:0]       pr_len = 8'h00;
    logic [7:0]       pr_body [BODY_N];
    logic [15:0]      sl_pos [SLOTS];
    logic             sl_valid [SLOTS];
    logic [7:0]       sl_stat [SLOTS];
    logic [31:0]      sl_rx [SLOTS];
    logic [31:0]      sl_ck [SLOTS];
    logic [7:0]       cfg_id [CFG_N];

    t_frame_result pending_frames [$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 0;
    int            rx_stall_pct = 0;

    // expectations typed in for the directed frames, reset slot IDs 1..4
    t_frame_result reset_expect [4] = '{
        '{ST_KNOWN,   8'h01, 1'b1, 2'd0, 8'h00, 1'b1, 16'h1234, 1'b1, 32'd1, 32'd0},
        '{ST_CKSUM,   8'h04, 1'b1, 2'd3, 8'hFF, 1'b0, 16'h0000, 1'b0, 32'd0, 32'd1},
        '{ST_UNKNOWN, 8'hFF, 1'b0, 2'd0, 8'h00, 1'b0, 16'h0000, 1'b0, 32'd0, 32'd0},
        '{ST_KNOWN,   8'h01, 1'b1, 2'd0, 8'h80, 1'b1, 16'h1234, 1'b1, 32'd2, 32'd0}
    };

    t_dir_row dir_table [38] = '{
        // position reply for slot 0
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'h01, -1}, '{8'h04, -1},
        '{8'h00, -1}, '{8'h12, -1}, '{8'h34, -1}, '{8'hB4, 0},
        // bad checksum for slot 3
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'h04, -1}, '{8'h02, -1},
        '{8'hFF, -1}, '{8'h00, 1},
        // broken second header byte
        '{8'hFF, -1}, '{8'h00, -1},
        // length too short, then too long
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'h05, -1}, '{8'h01, -1},
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'h05, -1}, '{8'h1D, -1},
        // good frame, unknown ID
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'hFF, -1}, '{8'h02, -1},
        '{8'h00, -1}, '{8'hFE, 2},
        // length-4 reply with nonzero status keeps the old position
        '{8'hFF, -1}, '{8'hFF, -1}, '{8'h01, -1}, '{8'h04, -1},
        '{8'h80, -1}, '{8'hAB, -1}, '{8'hCD, -1}, '{8'h02, 3}
    };

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void clear_parser();
        pr_count = '0;
        pr_size  = '0;
        pr_sum   = 8'h00;
    endfunction

    task automatic reset_predictor();
        clear_parser();
        pr_id  = 8'h00;
        pr_len = 8'h00;
        for (int i = 0; i < BODY_N; i++) pr_body[i] = 8'h00;
        for (int k = 0; k < SLOTS; k++) begin
            sl_pos[k]   = 16'h0000;
            sl_valid[k] = 1'b0;
            sl_stat[k]  = 8'h00;
            sl_rx[k]    = 32'd0;
            sl_ck[k]    = 32'd0;
        end
        for (int k = 0; k < CFG_N; k++) cfg_id[k] = 8'(k + 1);
    endtask

    task automatic predict_byte(input logic [7:0] b, output bit done, output t_frame_result r);
        int  idx;
        int  slot;
        bit  hit;
        bit  good;
        logic [7:0] sid;
        done = 1'b0;
        r    = '0;
        hit  = 1'b0;
        slot = 0;
        if (pr_count == 0) begin
            if (b == HDR_BYTE) pr_count = CNT_HDR1;
        end else if (pr_count == CNT_HDR1) begin
            if (b == HDR_BYTE) pr_count = POS_ID;
            else clear_parser();
        end else if (int'(pr_count) >= MAX_FRAME) begin
            clear_parser();
            if (b == HDR_BYTE) pr_count = CNT_HDR1;
        end else begin
            idx = int'(pr_count);
            pr_count = CNT_W'(idx + 1);
            if (idx == int'(POS_ID)) begin
                pr_id  = b;
                pr_sum = pr_sum + b;
            end else if (idx == int'(POS_LENB)) begin
                pr_len = b;
                pr_sum = pr_sum + b;
                if (b < MIN_LEN || int'(b) + int'(OVERHEAD) > MAX_FRAME) clear_parser();
                else pr_size = CNT_W'(b + OVERHEAD);
            end else if (idx + 1 != int'(pr_size)) begin
                pr_sum = pr_sum + b;
                if (idx - int'(BODY_POS) < BODY_N) pr_body[idx - int'(BODY_POS)] = b;
            end else begin
                // checksum byte closes the frame
                good = (b == ~pr_sum);
                for (int k = 0; k < SLOTS && !hit; k++) begin
                    sid = (k < CFG_N) ? cfg_id[k] : 8'(k + 1);
                    if (sid == pr_id) begin
                        hit  = 1'b1;
                        slot = k;
                    end
                end
                if (good) begin
                    r.pos_reply = (pr_len == POS_LEN);
                    r.status    = hit ? ST_KNOWN : ST_UNKNOWN;
                    if (hit) begin
                        sl_stat[slot] = pr_body[0];
                        sl_rx[slot]   = sl_rx[slot] + 32'd1;
                        if (r.pos_reply && pr_body[0] == 8'h00) begin
                            sl_pos[slot]   = {pr_body[1], pr_body[2]};
                            sl_valid[slot] = 1'b1;
                        end
                    end
                end else begin
                    r.status = ST_CKSUM;
                    if (hit) sl_ck[slot] = sl_ck[slot] + 32'd1;
                end
                r.id        = pr_id;
                r.hit       = hit;
                r.index     = hit ? 2'(slot) : 2'd0;
                r.stat_byte = pr_body[0];
                r.position  = hit ? sl_pos[slot] : 16'h0000;
                r.pos_known = hit ? sl_valid[slot] : 1'b0;
                r.rx_frames = hit ? sl_rx[slot] : 32'd0;
                r.ck_errors = hit ? sl_ck[slot] : 32'd0;
                done = 1'b1;
                clear_parser();
            end
        end
    endtask

    // sel >= 0 picks a typed expectation instead of the predicted one
    task automatic send_byte(input logic [7:0] b, input int sel);
        bit            done;
        t_frame_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        predict_byte(b, done, r);
        if (done) pending_frames.push_back((sel >= 0) ? reset_expect[sel] : r);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending_frames.size() != 0);
    endtask

    // finish any partial frame, let the pipeline empty, then load new slot IDs
    task automatic reconfigure(input logic [7:0] ids [CFG_N]);
        while (pr_count != 0) send_byte(8'h00, -1);
        hold_until_drained();
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
        for (int k = 0; k < CFG_N; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_SLOT0_ID + CFG_IDX_W'(k);
            i_cfg_data  <= ids[k];
            @(posedge i_clk);
            cfg_id[k] = ids[k];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return cfg_id[$urandom_range(CFG_N - 1)];
        if (roll < 80) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_burst();
        logic [7:0] fb [$];
        logic [7:0] id;
        logic [7:0] b;
        logic [7:0] sum;
        logic [7:0] cks;
        int         len;
        int         kind;
        int         roll;
        kind = $urandom_range(99);
        fb = {};
        if (kind < 85) begin
            roll = $urandom_range(99);
            if (roll < 55) len = 4;
            else if (roll < 85) len = $urandom_range(2, 6);
            else len = $urandom_range(2, MAX_FRAME - 4);
            id  = pick_id();
            sum = id + 8'(len);
            fb.push_back(HDR_BYTE);
            fb.push_back(HDR_BYTE);
            fb.push_back(id);
            fb.push_back(8'(len));
            for (int j = 1; j < len; j++) begin
                if (j == 1 && $urandom_range(9) < 6) b = 8'h00;
                else b = 8'($urandom_range(255));
                fb.push_back(b);
                sum = sum + b;
            end
            cks = ~sum;
            if ($urandom_range(99) < 15) cks = cks ^ 8'($urandom_range(1, 255));
            fb.push_back(cks);
            // cut the frame short
            if (kind >= 75) fb = fb[0:$urandom_range(1, fb.size() - 2)];
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 4)) begin
                fb.push_back(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom_range(255)));
            end
        end else if (kind < 96) begin
            fb.push_back(HDR_BYTE);
            fb.push_back(8'($urandom_range(254)));
        end else begin
            fb.push_back(HDR_BYTE);
            fb.push_back(HDR_BYTE);
            fb.push_back(pick_id());
            fb.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(1))
                                                 : 8'($urandom_range(MAX_FRAME - 3, 255)));
        end
        foreach (fb[j]) send_byte(fb[j], -1);
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        int target;
        target       = items_sent + PHASE_ITEMS;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (items_sent < target) begin
            send_random_burst();
            if ($urandom_range(199) == 0) hold_until_drained();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic check_frame();
        t_frame_result want;
        if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected frame, id %02h", o_frame_id));
            return;
        end
        want = pending_frames.pop_front();
        check_field("frame_status", 32'(o_frame_status), 32'(want.status));
        check_field("frame_id", 32'(o_frame_id), 32'(want.id));
        check_field("slot_hit", 32'(o_slot_hit), 32'(want.hit));
        check_field("slot_index", 32'(o_slot_index), 32'(want.index));
        check_field("status_byte", 32'(o_status_byte), 32'(want.stat_byte));
        check_field("position_reply", 32'(o_position_reply), 32'(want.pos_reply));
        check_field("position", 32'(o_position), 32'(want.position));
        check_field("position_known", 32'(o_position_known), 32'(want.pos_known));
        check_field("rx_frames", o_rx_frames, want.rx_frames);
        check_field("checksum_errors", o_checksum_errors, want.ck_errors);
    endtask

    // result side: check each transaction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) check_frame();
            i_res_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0] ids [CFG_N];
        reset_predictor();
        tx_idle_pct  = 21;
        rx_stall_pct = 66;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) send_byte(dir_table[i].rx, dir_table[i].sel);

        run_random_phase(21, 66);

        ids = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        reconfigure(ids);
        run_random_phase(21, 66);

        // duplicate IDs: the lowest slot wins
        ids = '{8'h10, 8'h10, 8'h20, 8'h10};
        reconfigure(ids);
        run_random_phase(66, 21);

        for (int k = 0; k < CFG_N; k++) ids[k] = 8'($urandom_range(255));
        reconfigure(ids);
        run_random_phase(66, 21);

        ids = '{8'hFF, 8'hFE, 8'h01, 8'h00};
        reconfigure(ids);
        run_random_phase(0, 0);

        hold_until_drained();
        repeat (RESULT_LATENCY + 6) @(posedge i_clk);
        if (pending_frames.size() != 0) begin
            report_mismatch($sformatf("%0d frames never emitted", pending_frames.size()));
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
